/* sv/lpfr_pkg.sv */
`default_nettype none

package lpfr_pkg;

  localparam logic [7:0] START_BYTE = 8'hAA;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_CMD  = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_SUM  = 3'd4
  } phase_t;

  // One result item as produced by the frame parser
  typedef struct packed {
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       payload_valid;
    logic [7:0] frame_command;
    logic [7:0] payload_length;
    logic       frame_done;
    logic       checksum_error;
  } result_t;

endpackage

`default_nettype wire

/* sv/lpfr_parser.sv */
`default_nettype none

module lpfr_parser
  import lpfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  output result_t         result
);

  phase_t     phase, phase_next;
  logic [7:0] command_hold, command_hold_next;
  logic [7:0] length_hold, length_hold_next;
  logic [7:0] payload_count, payload_count_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] count_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      command_hold  <= 8'd0;
      length_hold   <= 8'd0;
      payload_count <= 8'd0;
      running_sum   <= 8'd0;
    end else if (accept) begin
      phase         <= phase_next;
      command_hold  <= command_hold_next;
      length_hold   <= length_hold_next;
      payload_count <= payload_count_next;
      running_sum   <= running_sum_next;
    end
  end

  assign count_inc = payload_count + 8'd1;

  always_comb begin
    phase_next         = phase;
    command_hold_next  = command_hold;
    length_hold_next   = length_hold;
    payload_count_next = payload_count;
    running_sum_next   = running_sum;
    result             = '0;

    case (phase)
      PH_CMD: begin
        command_hold_next  = rx_byte;
        length_hold_next   = 8'd0;
        payload_count_next = 8'd0;
        running_sum_next   = rx_byte;
        phase_next         = PH_LEN;
      end
      PH_LEN: begin
        length_hold_next = rx_byte;
        running_sum_next = running_sum + rx_byte;
        phase_next       = (rx_byte == 8'd0) ? PH_SUM : PH_DATA;
      end
      PH_DATA: begin
        result.payload_byte  = rx_byte;
        result.payload_index = payload_count;
        result.payload_valid = 1'b1;
        running_sum_next     = running_sum + rx_byte;
        payload_count_next   = count_inc;
        if (count_inc >= length_hold) begin
          phase_next = PH_SUM;
        end
      end
      PH_SUM: begin
        result.frame_done     = (rx_byte == running_sum);
        result.checksum_error = (rx_byte != running_sum);
        phase_next            = PH_HUNT;
      end
      default: begin
        // hunt, and any stray code
        phase_next = (rx_byte == START_BYTE) ? PH_CMD : PH_HUNT;
      end
    endcase

    result.frame_command  = command_hold_next;
    result.payload_length = length_hold_next;
  end

endmodule

`default_nettype wire

/* sv/lpfr_out_buf.sv */
`default_nettype none

module lpfr_out_buf
  import lpfr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic load,
  input  result_t   result_in,
  input  wire logic out_ready,
  output logic      out_valid,
  output logic      can_load,
  output result_t   result_out
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

`default_nettype wire

/* sv/length_prefixed_frame_receiver_top.sv */
`default_nettype none

// Length-prefixed frame receiver. Each input item is one byte from a serial
// link. Bytes are dropped until the start byte 0xAA; then come a command
// byte, a length byte, that many payload bytes and a checksum byte, which
// must equal the 8-bit wrapping sum of command, length and payload. Every
// input item gives exactly one result item: payload bytes come out with
// payload_valid high and their index; the checksum byte raises frame_done
// or checksum_error. frame_command and payload_length show the held values
// after the byte (length reads 0 between command and length bytes). The
// checksum is kept as a running sum, so no frame is buffered.
// Rate: one item per clock while the output side keeps draining. The parser
// state updates in the cycle an item is accepted and the result lands in a
// single output register, valid in the cycle after acceptance; in_ready
// stays high while that register is empty or being drained.

module length_prefixed_frame_receiver_top
  import lpfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      payload_byte,
  output logic [7:0]      payload_index,
  output logic            payload_valid,
  output logic [7:0]      frame_command,
  output logic [7:0]      payload_length,
  output logic            frame_done,
  output logic            checksum_error
);

  logic    accept;
  result_t step_result;
  result_t held_result;

  // item taken when the output register is free or emptying this cycle
  assign accept = in_valid && in_ready;

  lpfr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .result  (step_result)
  );

  lpfr_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .result_in  (step_result),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .can_load   (in_ready),
    .result_out (held_result)
  );

  assign payload_byte   = held_result.payload_byte;
  assign payload_index  = held_result.payload_index;
  assign payload_valid  = held_result.payload_valid;
  assign frame_command  = held_result.frame_command;
  assign payload_length = held_result.payload_length;
  assign frame_done     = held_result.frame_done;
  assign checksum_error = held_result.checksum_error;

endmodule

`default_nettype wire

/* dv/length_prefixed_frame_receiver_top_test.sv */
`default_nettype none

module length_prefixed_frame_receiver_top_test;
  import lpfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 10;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic [7:0] rx_byte = 8'd0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic       payload_valid;
  logic [7:0] frame_command;
  logic [7:0] payload_length;
  logic       frame_done;
  logic       checksum_error;

  length_prefixed_frame_receiver_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .payload_byte(payload_byte),
    .payload_index(payload_index),
    .payload_valid(payload_valid),
    .frame_command(frame_command),
    .payload_length(payload_length),
    .frame_done(frame_done),
    .checksum_error(checksum_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bytes waiting to be sent, and results owed by the parser
  logic [7:0] link_bytes[$];
  result_t    frame_results_due[$];

  int  mismatches = 0;
  int  bytes_queued = 0;
  int  tx_gap_left = 0;
  int  rx_stall_left = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;   // set for the closing stretch: no idling either side

  // parser state, mirrors what the block should hold
  phase_t     rx_phase = PH_HUNT;
  logic [7:0] cmd_held = 8'd0;
  logic [7:0] len_held = 8'd0;
  logic [7:0] data_count = 8'd0;
  logic [7:0] sum_acc = 8'd0;

  // Predict the one result item caused by a received byte, advancing the
  // parser state as it goes.
  function automatic result_t parse_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    case (rx_phase)
      PH_CMD: begin
        cmd_held   = b;
        len_held   = 8'd0;
        data_count = 8'd0;
        sum_acc    = b;
        rx_phase   = PH_LEN;
      end
      PH_LEN: begin
        len_held = b;
        sum_acc  = sum_acc + b;
        rx_phase = (b == 8'd0) ? PH_SUM : PH_DATA;
      end
      PH_DATA: begin
        r.payload_byte  = b;
        r.payload_index = data_count;
        r.payload_valid = 1'b1;
        sum_acc    = sum_acc + b;
        data_count = data_count + 8'd1;
        if (data_count >= len_held) rx_phase = PH_SUM;
      end
      PH_SUM: begin
        r.frame_done     = (b == sum_acc);
        r.checksum_error = (b != sum_acc);
        rx_phase = PH_HUNT;
      end
      default: begin
        // hunting: everything but the start byte is dropped
        rx_phase = (b == START_BYTE) ? PH_CMD : PH_HUNT;
      end
    endcase
    r.frame_command  = cmd_held;
    r.payload_length = len_held;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch on %s: got 0x%0h, want 0x%0h", field, got, want);
    mismatches++;
  endtask

  // Sender: one item per free slot, with random gaps.
  always @(posedge clk) begin : link_driver
    logic holding;
    if (rst) begin
      in_valid    <= 1'b0;
      tx_gap_left = 0;
    end else begin
      holding = in_valid;
      if (in_valid && in_ready) begin
        frame_results_due.push_back(parse_byte(rx_byte));
        holding = 1'b0;
      end
      if (!holding) begin
        if (!quiet && tx_gap_left > 0) begin
          tx_gap_left--;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
          tx_gap_left = $urandom_range(1, 18) - 1;
        end else if (link_bytes.size() > 0) begin
          rx_byte <= link_bytes.pop_front();
          holding = 1'b1;
        end
      end
      in_valid <= holding;
    end
  end

  // Receiver: random back-pressure bursts.
  always @(posedge clk) begin
    if (rst) begin
      out_ready     <= 1'b0;
      rx_stall_left = 0;
    end else if (!quiet && rx_stall_left > 0) begin
      rx_stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      rx_stall_left = $urandom_range(1, 18) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker: every accepted result against the oldest prediction.
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (frame_results_due.size() == 0) begin
        $display("result item with none outstanding (byte 0x%0h)", payload_byte);
        mismatches++;
      end else begin
        want = frame_results_due.pop_front();
        if (payload_byte != want.payload_byte)
          report_mismatch("payload_byte", payload_byte, want.payload_byte);
        if (payload_index != want.payload_index)
          report_mismatch("payload_index", payload_index, want.payload_index);
        if (payload_valid != want.payload_valid)
          report_mismatch("payload_valid", payload_valid, want.payload_valid);
        if (frame_command != want.frame_command)
          report_mismatch("frame_command", frame_command, want.frame_command);
        if (payload_length != want.payload_length)
          report_mismatch("payload_length", payload_length, want.payload_length);
        if (frame_done != want.frame_done)
          report_mismatch("frame_done", frame_done, want.frame_done);
        if (checksum_error != want.checksum_error)
          report_mismatch("checksum_error", checksum_error, want.checksum_error);
      end
    end
  end

  // Watchdog: too long without any item moving on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("length_prefixed_frame_receiver_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_link_byte(input logic [7:0] b);
    link_bytes.push_back(b);
    bytes_queued++;
  endtask

  // Whole frame; the checksum is spoiled when asked. A short frame leaves
  // the parser still in payload, so the next bytes get swallowed as data.
  task automatic send_frame(input logic [7:0] cmd, input int unsigned len,
                            input bit corrupt, input int unsigned cut_at);
    logic [7:0] sum;
    logic [7:0] b;
    queue_link_byte(START_BYTE);
    queue_link_byte(cmd);
    queue_link_byte(len[7:0]);
    sum = cmd + len[7:0];
    for (int unsigned i = 0; i < len; i++) begin
      if (i == cut_at) return;
      b = 8'($urandom_range(0, 255));
      sum = sum + b;
      queue_link_byte(b);
    end
    if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
    queue_link_byte(sum);
  endtask

  task automatic send_mix(input int target);
    int unsigned len;
    while (bytes_queued < target) begin
      // line noise between frames, now and then a stray start byte
      repeat ($urandom_range(0, 2)) queue_link_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 24) == 0) len = $urandom_range(7, 40);
      else len = $urandom_range(0, 6);
      send_frame(8'($urandom_range(0, 255)), len, $urandom_range(0, 3) == 0,
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 1000);
    end
  endtask

  task automatic wait_drained();
    while (link_bytes.size() != 0 || in_valid || frame_results_due.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: noise while hunting, zero length frame with top command,
    // start byte as command with extreme payload and a bad checksum,
    // a dropped byte after the frame end, start byte as payload
    queue_link_byte(8'h00);
    queue_link_byte(8'hFF);
    queue_link_byte(8'h55);
    queue_link_byte(START_BYTE); queue_link_byte(8'hFF); queue_link_byte(8'h00);
    queue_link_byte(8'hFF);
    queue_link_byte(START_BYTE); queue_link_byte(START_BYTE); queue_link_byte(8'h03);
    queue_link_byte(8'h00); queue_link_byte(8'hFF); queue_link_byte(8'h80);
    queue_link_byte(8'h2D);
    queue_link_byte(8'h12);
    queue_link_byte(START_BYTE); queue_link_byte(8'h00); queue_link_byte(8'h01);
    queue_link_byte(START_BYTE); queue_link_byte(8'hAB);
    wait_drained();

    // longest frame: payload index runs up to 254
    send_frame(8'($urandom_range(0, 255)), 255, 1'b0, 1000);
    send_mix(320);

    // wait until everything owed has arrived
    wait_drained();

    send_mix(390);
    wait_drained();
    quiet = 1'b1;
    send_mix(450);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0 && frame_results_due.size() == 0) begin
      $display("length_prefixed_frame_receiver_top regression: pass");
    end else begin
      $display("length_prefixed_frame_receiver_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
